// File: rtl/core/assert_macros.svh
// Assertion helpers. Expect clk_i and rst_ni in the enclosing module.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`define ASSERT_ALWAYS(label, prop, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);

`define ASSERT_NEVER(label, cond, msg) \
  `ASSERT_ALWAYS(label, !(cond), msg)

`endif

// File: rtl/core/tnw_pkg.sv
package tnw_pkg;

  localparam int VAL_W = 32;
  localparam int POS_W = 32;
  localparam int CAP_W = 4;

  typedef struct packed {
    logic signed [VAL_W-1:0] value;
    logic [POS_W-1:0]        pos;
  } entry_t;

  // (value, position) order, value compared as signed
  function automatic logic pair_less(entry_t a, entry_t b);
    logic r;
    if (a.value != b.value) begin
      r = (a.value < b.value);
    end else begin
      r = (a.pos < b.pos);
    end
    return r;
  endfunction

endpackage

// File: rtl/core/top_n_column_winsorizer.sv
// Channel   Handshake              Payload
// in        in_valid_i/in_ready_o  sample_value_i, entry_position_i, column_end_i
// out       out_valid_o/out_ready_i write_position_o, clamped_value_o, run_last_o
// cfg       cfg_we_i               cfg_wdata_i (cap_count)
//
// An item into an empty store is written at once. Otherwise it is appended at the top, or, when the
// store is full, it replaces the smallest entry or is dropped; kept entries are moved to make room.
// All moves go through the one-read, one-write kept store, one entry per cycle.
// A column end that rewrites first reads the smallest kept value, then waits on out for each rewrite.
// in_ready_o is high only while no item is in work and no rewrite is pending.
// Reset clears the fill count, column length and cap; the store needs no clearing.
`include "assert_macros.svh"

module top_n_column_winsorizer
  import tnw_pkg::*;
#(
  parameter int KEEP_DEPTH = 16
) (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  logic                    in_valid_i,
  output logic                    in_ready_o,
  input  logic signed [VAL_W-1:0] sample_value_i,
  input  logic [POS_W-1:0]        entry_position_i,
  input  logic                    column_end_i,
  output logic                    out_valid_o,
  input  logic                    out_ready_i,
  output logic [POS_W-1:0]        write_position_o,
  output logic signed [VAL_W-1:0] clamped_value_o,
  output logic                    run_last_o,
  input  logic                    cfg_we_i,
  input  logic [CAP_W-1:0]        cfg_wdata_i
);

  localparam int AW = (KEEP_DEPTH > 1) ? $clog2(KEEP_DEPTH) : 1;
  localparam int FW = $clog2(KEEP_DEPTH + 1);
  localparam int LW = $clog2(KEEP_DEPTH + 2);
  localparam int KW = ((FW > CAP_W) ? FW : CAP_W) + 1;
  localparam logic [KW-1:0] N_MAX   = KW'(KEEP_DEPTH - 1);
  localparam logic [LW-1:0] LEN_MAX = LW'(KEEP_DEPTH + 1);

  typedef enum logic [8:0] {
    S_IDLE    = 9'b000000001,
    S_APP_CMP = 9'b000000010,
    S_REP_CHK = 9'b000000100,
    S_REP_CMP = 9'b000001000,
    S_PLACE   = 9'b000010000,
    S_POST    = 9'b000100000,
    S_LOW     = 9'b001000000,
    S_DR_CAP  = 9'b010000000,
    S_DR_OUT  = 9'b100000000
  } state_e;

  state_e                  state_q, state_d;
  logic [CAP_W-1:0]        cap_q;
  logic [FW-1:0]           fill_q, fill_d;
  logic [LW-1:0]           len_q, len_d;
  logic [AW-1:0]           k_q, k_d;
  entry_t                  new_q, new_d;
  logic                    last_q, last_d;
  logic signed [VAL_W-1:0] low_q, low_d;
  logic                    oval_q, oval_d;
  logic [POS_W-1:0]        wpos_q, wpos_d;
  logic signed [VAL_W-1:0] cval_q, cval_d;
  logic                    rlast_q, rlast_d;

  logic          st_we;
  logic [AW-1:0] st_waddr, st_raddr;
  entry_t        st_wdata, st_rdata;

  logic [KW-1:0] cap_ext, n_w, keep_w, fill_ext, len_ext;
  logic          append_w;
  entry_t        in_entry;

  tnw_store #(
    .DEPTH (KEEP_DEPTH),
    .AW    (AW)
  ) u_store (
    .clk_i   (clk_i),
    .we_i    (st_we),
    .waddr_i (st_waddr),
    .wdata_i (st_wdata),
    .raddr_i (st_raddr),
    .rdata_o (st_rdata)
  );

  assign cap_ext  = KW'(cap_q);
  assign n_w      = (cap_ext > N_MAX) ? N_MAX : cap_ext;
  assign keep_w   = n_w + KW'(1);
  assign fill_ext = KW'(fill_q);
  assign len_ext  = KW'(len_q);
  assign append_w = (fill_ext < keep_w);
  assign in_entry = '{value: sample_value_i, pos: entry_position_i};

  always_comb begin
    state_d  = state_q;
    fill_d   = fill_q;
    len_d    = len_q;
    k_d      = k_q;
    new_d    = new_q;
    last_d   = last_q;
    low_d    = low_q;
    oval_d   = oval_q;
    wpos_d   = wpos_q;
    cval_d   = cval_q;
    rlast_d  = rlast_q;
    st_we    = 1'b0;
    st_waddr = k_q;
    st_wdata = new_q;
    st_raddr = AW'(0);

    case (state_q)
      S_IDLE: begin
        // prefetch the entry the newcomer is first compared with
        st_raddr = append_w ? AW'(fill_q - FW'(1)) : AW'(0);
        if (in_valid_i) begin
          new_d  = in_entry;
          last_d = column_end_i;
          len_d  = (len_q == LEN_MAX) ? len_q : len_q + LW'(1);
          if (append_w) begin
            fill_d = fill_q + FW'(1);
            k_d    = AW'(fill_q);
            if (fill_q == '0) begin
              st_we    = 1'b1;
              st_waddr = AW'(0);
              st_wdata = in_entry;
              state_d  = S_POST;
            end else begin
              state_d = S_APP_CMP;
            end
          end else begin
            k_d     = AW'(0);
            state_d = S_REP_CHK;
          end
        end
      end

      // walk down from the top, moving larger entries up one slot
      S_APP_CMP: begin
        st_we = 1'b1;
        if (pair_less(new_q, st_rdata)) begin
          st_wdata = st_rdata;
          k_d      = k_q - AW'(1);
          if (k_q == AW'(1)) begin
            state_d = S_PLACE;
          end else begin
            st_raddr = k_q - AW'(2);
          end
        end else begin
          state_d = S_POST;
        end
      end

      // full store: newcomer must beat the smallest value strictly
      S_REP_CHK: begin
        if (new_q.value > st_rdata.value) begin
          if (fill_q == FW'(1)) begin
            state_d = S_PLACE;
          end else begin
            st_raddr = AW'(1);
            state_d  = S_REP_CMP;
          end
        end else begin
          state_d = S_POST;
        end
      end

      // walk up from the bottom, moving smaller entries down over the dropped one
      S_REP_CMP: begin
        st_we = 1'b1;
        if (!pair_less(new_q, st_rdata)) begin
          st_wdata = st_rdata;
          k_d      = k_q + AW'(1);
          if (KW'(k_q) + KW'(2) == fill_ext) begin
            state_d = S_PLACE;
          end else begin
            st_raddr = k_q + AW'(2);
          end
        end else begin
          state_d = S_POST;
        end
      end

      S_PLACE: begin
        st_we   = 1'b1;
        state_d = S_POST;
      end

      S_POST: begin
        if (last_q) begin
          if ((len_ext > keep_w) && (fill_q > FW'(1))) begin
            st_raddr = AW'(0);
            state_d  = S_LOW;
          end else begin
            fill_d  = '0;
            len_d   = '0;
            state_d = S_IDLE;
          end
        end else begin
          state_d = S_IDLE;
        end
      end

      S_LOW: begin
        low_d    = st_rdata.value;
        st_raddr = AW'(1);
        k_d      = AW'(1);
        state_d  = S_DR_CAP;
      end

      S_DR_CAP: begin
        oval_d  = 1'b1;
        wpos_d  = st_rdata.pos;
        cval_d  = low_q;
        rlast_d = (KW'(k_q) + KW'(1) == fill_ext);
        state_d = S_DR_OUT;
      end

      S_DR_OUT: begin
        if (out_ready_i) begin
          oval_d = 1'b0;
          if (rlast_q) begin
            fill_d  = '0;
            len_d   = '0;
            state_d = S_IDLE;
          end else begin
            k_d      = k_q + AW'(1);
            st_raddr = k_q + AW'(1);
            state_d  = S_DR_CAP;
          end
        end
      end

      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      cap_q   <= '0;
      fill_q  <= '0;
      len_q   <= '0;
      oval_q  <= 1'b0;
    end else begin
      state_q <= state_d;
      fill_q  <= fill_d;
      len_q   <= len_d;
      oval_q  <= oval_d;
      if (cfg_we_i) begin
        cap_q <= cfg_wdata_i;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    k_q     <= k_d;
    new_q   <= new_d;
    last_q  <= last_d;
    low_q   <= low_d;
    wpos_q  <= wpos_d;
    cval_q  <= cval_d;
    rlast_q <= rlast_d;
  end

  assign in_ready_o       = (state_q == S_IDLE);
  assign out_valid_o      = oval_q;
  assign write_position_o = wpos_q;
  assign clamped_value_o  = cval_q;
  assign run_last_o       = rlast_q;

  `ASSERT_NEVER(a_ready_while_out, in_ready_o && out_valid_o, "input taken during drain")
  `ASSERT_ALWAYS(a_fill_range, int'(fill_q) <= KEEP_DEPTH, "fill count beyond depth")
  `ASSERT_ALWAYS(a_busy_after_in, (in_valid_i && in_ready_o) |=> !in_ready_o, "no work after transaction")
  `ASSERT_ALWAYS(a_clear_after_run, (out_valid_o && out_ready_i && run_last_o) |=> (fill_q == '0 && len_q == '0), "store not cleared after run")

endmodule

// File: rtl/core/tnw_store.sv
module tnw_store
  import tnw_pkg::*;
#(
  parameter int DEPTH = 16,
  parameter int AW    = 4
) (
  input  logic          clk_i,
  input  logic          we_i,
  input  logic [AW-1:0] waddr_i,
  input  entry_t        wdata_i,
  input  logic [AW-1:0] raddr_i,
  output entry_t        rdata_o
);

  entry_t mem [DEPTH];
  entry_t rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
  end

  always_ff @(posedge clk_i) begin
    rdata_q <= mem[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule
